// ----- rtl/core/pap_pkg.sv -----
`default_nettype none

package pap_pkg;

    localparam int COORD_BITS  = 16;
    localparam int FRAC_BITS   = 16;
    localparam int AREA_BITS   = 43;
    localparam int PERIM_BITS  = 43;
    localparam int LSUM_BITS   = 44;
    localparam int OPND_BITS   = COORD_BITS + 1;
    localparam int PROD_BITS   = 2 * OPND_BITS;
    localparam int RAD_BITS    = 2 * COORD_BITS + 2;
    localparam int ROOT_BITS   = RAD_BITS / 2 + FRAC_BITS;
    localparam int SQ_STEPS    = ROOT_BITS;
    localparam int SQ_CNT_BITS = $clog2(SQ_STEPS);
    localparam int REM_BITS    = ROOT_BITS + 3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_ROOT,
        S_ACC,
        S_OUT
    } t_state;

    typedef enum logic [2:0] {
        MS_DXX,
        MS_DYY,
        MS_AXBY,
        MS_BXAY,
        MS_LAST
    } t_mul_step;

endpackage

`default_nettype wire

// ----- rtl/core/pap_vtx_if.sv -----
`default_nettype none

interface pap_vtx_if;
    import pap_pkg::*;

    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] x_coord;
    logic signed [COORD_BITS-1:0] y_coord;
    logic                         last_vertex;

    modport source (output valid, output x_coord, output y_coord, output last_vertex,
                    input ready);
    modport sink   (input valid, input x_coord, input y_coord, input last_vertex,
                    output ready);
endinterface

`default_nettype wire

// ----- rtl/core/pap_res_if.sv -----
`default_nettype none

interface pap_res_if;
    import pap_pkg::*;

    logic                        valid;
    logic                        ready;
    logic signed [AREA_BITS-1:0] signed_area_halves;
    logic        [PERIM_BITS-1:0] perimeter_fixed;

    modport source (output valid, output signed_area_halves, output perimeter_fixed,
                    input ready);
    modport sink   (input valid, input signed_area_halves, input perimeter_fixed,
                    output ready);
endinterface

`default_nettype wire

// ----- rtl/core/pap_sqrt.sv -----
`default_nettype none

module pap_sqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [pap_pkg::RAD_BITS-1:0]  i_radicand,
    output logic                          o_done,
    output logic [pap_pkg::ROOT_BITS-1:0] o_root
);
    import pap_pkg::*;

    logic                     r_busy, n_busy;
    logic                     r_done, n_done;
    logic [SQ_CNT_BITS-1:0]   r_cnt, n_cnt;
    logic [2*ROOT_BITS-1:0]   r_rad, n_rad;
    logic [REM_BITS-1:0]      r_rem, n_rem;
    logic [ROOT_BITS-1:0]     r_root, n_root;
    logic [REM_BITS-1:0]      rem_sh;
    logic [REM_BITS-1:0]      trial;

    // one result bit per step, two radicand bits in
    always_comb begin
        rem_sh = {r_rem[REM_BITS-3:0], r_rad[2*ROOT_BITS-1 -: 2]};
        trial  = REM_BITS'({r_root, 2'b01});
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rad  = r_rad;
        n_rem  = r_rem;
        n_root = r_root;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rad  = {i_radicand, (2*ROOT_BITS-RAD_BITS)'(0)};
            n_rem  = '0;
            n_root = '0;
        end else if (r_busy) begin
            n_rad = {r_rad[2*ROOT_BITS-3:0], 2'b00};
            if (rem_sh >= trial) begin
                n_rem  = rem_sh - trial;
                n_root = {r_root[ROOT_BITS-2:0], 1'b1};
            end else begin
                n_rem  = rem_sh;
                n_root = {r_root[ROOT_BITS-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == SQ_CNT_BITS'(SQ_STEPS-1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rad  <= n_rad;
        r_rem  <= n_rem;
        r_root <= n_root;
    end

    assign o_done = r_done;
    assign o_root = r_root;

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> r_busy)
        else $error("root unit did not start");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt <= SQ_CNT_BITS'(SQ_STEPS-1)))
        else $error("root step count overran");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && !i_start) |-> !r_busy)
        else $error("root done while still busy");

endmodule

`default_nettype wire

// ----- rtl/core/polygon_area_perimeter_top.sv -----
// polygon area and perimeter, one vertex per input beat
//
// i_vtx: valid/ready channel of vertices (x_coord, y_coord, last_vertex).
// o_res: valid/ready channel, one beat per polygon, sent after its last
//   vertex: signed_area_halves (twice the signed area, exact) and
//   perimeter_fixed (edge lengths summed, 16 fraction bits, saturating).
// each edge runs four products through one 17x17 multiplier and one
//   bit-serial square root (33 root bits, one a cycle, done flag registered),
//   then adds the cross product and the root into the sums.
// the first vertex of a polygon is only accepted; a middle vertex is accepted
//   and its edge run; the last vertex is accepted, its edge and the closing
//   edge run, then the result register is loaded once it is free. ready is
//   high only between items.
// a single vertex polygon gives zero area and zero perimeter.
// the result sits in an output register: a new vertex is taken while it
//   waits, but the next polygon's result holds until the receiver takes it.
// reset (synchronous, active low) clears the sums, drops any partial
//   polygon and empties the output register.
`default_nettype none

module polygon_area_perimeter_top (
    input  logic i_clk,
    input  logic i_rst_n,
    pap_vtx_if.sink   i_vtx,
    pap_res_if.source o_res
);
    import pap_pkg::*;

    t_state                        r_state, n_state;
    t_mul_step                     r_step;
    logic signed [COORD_BITS-1:0]  r_cur_x, r_cur_y;
    logic signed [COORD_BITS-1:0]  r_first_x, r_first_y;
    logic signed [COORD_BITS-1:0]  r_prev_x, r_prev_y;
    logic                          r_last;
    logic                          r_have_first;
    logic                          r_closing;
    logic signed [PROD_BITS-1:0]   r_prod;
    logic        [RAD_BITS-1:0]    r_sq;
    logic signed [PROD_BITS-1:0]   r_cross;
    logic        [AREA_BITS-1:0]   r_cross_sum;
    logic        [LSUM_BITS-1:0]   r_len_sum;
    logic                          r_out_valid;
    logic signed [AREA_BITS-1:0]   r_out_area;
    logic        [PERIM_BITS-1:0]  r_out_perim;

    logic signed [COORD_BITS-1:0]  a_x, a_y, b_x, b_y;
    logic signed [OPND_BITS-1:0]   dx, dy, mul_a, mul_b;
    logic signed [PROD_BITS-1:0]   product;
    logic                          take;
    logic                          out_free;
    logic                          sq_start;
    logic                          sq_done;
    logic        [ROOT_BITS-1:0]   sq_root;
    logic        [LSUM_BITS:0]     len_add;
    logic        [PERIM_BITS-1:0]  perim_sat;

    // edge endpoints: running edge, or closing edge back to the first vertex
    always_comb begin
        a_x = r_closing ? r_cur_x   : r_prev_x;
        a_y = r_closing ? r_cur_y   : r_prev_y;
        b_x = r_closing ? r_first_x : r_cur_x;
        b_y = r_closing ? r_first_y : r_cur_y;
        dx  = OPND_BITS'(a_x) - OPND_BITS'(b_x);
        dy  = OPND_BITS'(a_y) - OPND_BITS'(b_y);
        unique case (r_step)
            MS_DXX:  begin mul_a = dx;               mul_b = dx;               end
            MS_DYY:  begin mul_a = dy;               mul_b = dy;               end
            MS_AXBY: begin mul_a = OPND_BITS'(a_x);  mul_b = OPND_BITS'(b_y);  end
            MS_BXAY: begin mul_a = OPND_BITS'(b_x);  mul_b = OPND_BITS'(a_y);  end
            default: begin mul_a = '0;               mul_b = '0;               end
        endcase
        product   = mul_a * mul_b;
        len_add   = {1'b0, r_len_sum} + (LSUM_BITS+1)'(sq_root);
        perim_sat = (|r_len_sum[LSUM_BITS-1:PERIM_BITS]) ? '1 : r_len_sum[PERIM_BITS-1:0];
    end

    pap_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sq_start),
        .i_radicand (r_sq),
        .o_done     (sq_done),
        .o_root     (sq_root)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_vtx.valid && (r_have_first || i_vtx.last_vertex)) n_state = S_MUL;
            S_MUL:  if (r_step == MS_LAST) n_state = S_ROOT;
            S_ROOT: if (sq_done) n_state = S_ACC;
            S_ACC: begin
                if (r_closing)   n_state = S_OUT;
                else if (r_last) n_state = S_MUL;
                else             n_state = S_IDLE;
            end
            S_OUT:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        out_free    = !r_out_valid || o_res.ready;
        i_vtx.ready = (r_state == S_IDLE);
        take        = i_vtx.valid && (r_state == S_IDLE);
        sq_start    = (r_state == S_MUL) && (r_step == MS_LAST);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_step       <= MS_DXX;
            r_have_first <= 1'b0;
            r_closing    <= 1'b0;
            r_cross_sum  <= '0;
            r_len_sum    <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= (r_state == S_MUL) ? t_mul_step'(r_step + 1'b1) : MS_DXX;
            if (take) begin
                if (!r_have_first) begin
                    r_have_first <= 1'b1;
                    r_closing    <= i_vtx.last_vertex;
                end else begin
                    r_closing <= 1'b0;
                end
            end
            if (r_state == S_ACC) begin
                r_cross_sum <= r_cross_sum + AREA_BITS'(r_cross);
                r_len_sum   <= len_add[LSUM_BITS] ? '1 : len_add[LSUM_BITS-1:0];
                if (r_last && !r_closing) r_closing <= 1'b1;
            end
            if (r_state == S_OUT && out_free) begin
                r_out_valid  <= 1'b1;
                r_cross_sum  <= '0;
                r_len_sum    <= '0;
                r_have_first <= 1'b0;
                r_closing    <= 1'b0;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (take) begin
            r_cur_x <= i_vtx.x_coord;
            r_cur_y <= i_vtx.y_coord;
            r_last  <= i_vtx.last_vertex;
            if (!r_have_first) begin
                r_first_x <= i_vtx.x_coord;
                r_first_y <= i_vtx.y_coord;
                if (!i_vtx.last_vertex) begin
                    r_prev_x <= i_vtx.x_coord;
                    r_prev_y <= i_vtx.y_coord;
                end
            end
        end
        if (r_state == S_ACC && !r_closing) begin
            r_prev_x <= r_cur_x;
            r_prev_y <= r_cur_y;
        end
        if (r_state == S_MUL) begin
            r_prod <= product;
            unique case (r_step)
                MS_DYY:  r_sq    <= RAD_BITS'(r_prod);
                MS_AXBY: r_sq    <= r_sq + RAD_BITS'(r_prod);
                MS_BXAY: r_cross <= r_prod;
                MS_LAST: r_cross <= r_cross - r_prod;
                default: ;
            endcase
        end
        if (r_state == S_OUT && out_free) begin
            r_out_area  <= r_cross_sum;
            r_out_perim <= perim_sat;
        end
    end

    assign o_res.valid              = r_out_valid;
    assign o_res.signed_area_halves = r_out_area;
    assign o_res.perimeter_fixed    = r_out_perim;

    a_done_in_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sq_done |-> (r_state == S_ROOT))
        else $error("root result outside root phase");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && !r_out_valid) |=> r_out_valid)
        else $error("result not loaded into free output register");

    a_mid_vertex_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACC && !r_closing && !r_last) |=> (r_state == S_IDLE))
        else $error("middle vertex did not return to idle");

endmodule

`default_nettype wire
